[rtl/cht_pkg.sv]
// Package for the chained hash table engine: item and result types, status
// and operation codes and the sequencer state enum. No dependencies.
`default_nettype none
package cht_pkg;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] key;
        logic [31:0] value;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_value;
    } t_result;

    localparam logic [1:0] OP_FIND   = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_MISS    = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;
    localparam logic [1:0] STAT_KEYZERO = 2'd3;

    localparam int unsigned CFG_W    = 12;
    localparam int unsigned KEY_W    = 32;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_HRD,
        ST_HCHK,
        ST_NRD,
        ST_NCHK,
        ST_FOUND,
        ST_ABSENT,
        ST_RMH_RD,
        ST_RMH_WR,
        ST_RMN_PREV,
        ST_RMN_REL,
        ST_ADD_RD,
        ST_ADD_NODE,
        ST_ADD_LINK
    } t_state;

endpackage
`default_nettype wire

[rtl/cht_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

[rtl/cht_div.sv]
// Bit-serial restoring remainder unit: 32-bit key modulo bucket count.
// Depends on cht_pkg.
`default_nettype none
module cht_div #(
    parameter int DW = 12
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [cht_pkg::KEY_W-1:0] i_dividend,
    input  wire logic [DW-1:0]           i_divisor,
    output logic                         o_done,
    output logic      [DW-1:0]           o_rem
);
    import cht_pkg::*;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [4:0]       r_cnt, n_cnt;
    logic [KEY_W-1:0] r_q, n_q;
    logic [DW-1:0]    r_rem, n_rem;
    logic [DW-1:0]    r_div, n_div;
    logic [DW:0]      trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_div  = r_div;
        trial  = {r_rem, r_q[KEY_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd0;
            n_q    = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            // shift in one dividend bit, subtract when it fits
            if (trial >= {1'b0, r_div}) begin
                trial = trial - {1'b0, r_div};
            end
            n_rem = trial[DW-1:0];
            n_q   = {r_q[KEY_W-2:0], 1'b0};
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

[rtl/chained_hash_table_engine_core.sv]
// Chained hash table engine: top level with sequencer, bucket and node RAMs.
// Depends on cht_pkg, cht_ram and cht_div.
// Throughput: one item at a time; busy stays high until the result strobe.
// Reset: synchronous; a clearing pass over max(BUCKETS, POOL_NODES) addresses
//   empties every bucket and threads the free list while busy is high.
// The receiver cannot stall: o_done marks the result for exactly one cycle.
`default_nettype none
module chained_hash_table_engine_core #(
    parameter int BUCKETS    = 2048,
    parameter int POOL_NODES = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire cht_pkg::t_item                i_item,
    output logic                               o_done,
    output cht_pkg::t_result                   o_result,
    input  wire logic                          i_cfg_we,
    input  wire logic [cht_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import cht_pkg::*;

    localparam int BW   = $clog2(BUCKETS);
    localparam int NW   = $clog2(POOL_NODES);
    localparam int LW   = $clog2(POOL_NODES + 1);
    localparam int NBW  = $clog2(BUCKETS + 1);
    localparam int CLRN = (BUCKETS > POOL_NODES) ? BUCKETS : POOL_NODES;
    localparam int CLW  = $clog2(CLRN + 1);

    // one RAM word per head slot or pool node
    typedef struct packed {
        logic [31:0]   key;
        logic [31:0]   value;
        logic [LW-1:0] link;
    } t_entry;

    localparam int EW = $bits(t_entry);

    function automatic logic link_ok(input logic [LW-1:0] l);
        return (l != '0) && (l <= LW'(POOL_NODES));
    endfunction

    function automatic logic [NW-1:0] idx_of(input logic [LW-1:0] l);
        logic [LW-1:0] t;
        t = l - LW'(1);
        return t[NW-1:0];
    endfunction

    t_state          r_state, n_state;
    logic [CFG_W-1:0] r_cfg;
    logic [1:0]      r_op, n_op;
    logic [31:0]     r_key, n_key;
    logic [31:0]     r_val, n_val;
    logic [NBW-1:0]  r_nb, n_nb;
    logic [BW-1:0]   r_bucket, n_bucket;
    t_entry          r_head, n_head;
    t_entry          r_nent, n_nent;
    t_entry          r_pent, n_pent;
    logic [LW-1:0]   r_prev, n_prev;
    logic [LW-1:0]   r_cur, n_cur;
    logic [LW-1:0]   r_free, n_free;
    logic [LW-1:0]   r_new, n_new;
    logic [LW-1:0]   r_steps, n_steps;
    logic            r_hit_head, n_hit_head;
    logic [CLW-1:0]  r_clr, n_clr;
    logic            r_done, n_done;
    t_result         r_res, n_res;

    logic            h_we, nd_we;
    logic [BW-1:0]   h_addr;
    logic [NW-1:0]   nd_addr;
    t_entry          h_wdata, nd_wdata, h_rd, nd_rd;
    logic            div_start, div_done;
    logic [NBW-1:0]  div_rem;
    logic            is_add, is_rm;

    assign is_add = (r_op == OP_ADD);
    assign is_rm  = (r_op == OP_REMOVE);

    cht_ram #(.WIDTH(EW), .DEPTH(BUCKETS)) u_head_ram (
        .i_clk  (i_clk),
        .i_we   (h_we),
        .i_waddr(h_addr),
        .i_wdata(h_wdata),
        .i_raddr(h_addr),
        .o_rdata(h_rd)
    );

    cht_ram #(.WIDTH(EW), .DEPTH(POOL_NODES)) u_node_ram (
        .i_clk  (i_clk),
        .i_we   (nd_we),
        .i_waddr(nd_addr),
        .i_wdata(nd_wdata),
        .i_raddr(nd_addr),
        .o_rdata(nd_rd)
    );

    // load the divider with the incoming key and the clamped bucket count
    cht_div #(.DW(NBW)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(n_key),
        .i_divisor (n_nb),
        .o_done    (div_done),
        .o_rem     (div_rem)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == CLW'(CLRN - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start && i_item.key != '0) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) n_state = ST_HRD;
            end
            ST_HRD: n_state = ST_HCHK;
            ST_HCHK: begin
                if (h_rd.key == '0) n_state = ST_ABSENT;
                else if (h_rd.key == r_key) n_state = ST_FOUND;
                else if (link_ok(h_rd.link)) n_state = ST_NRD;
                else n_state = ST_ABSENT;
            end
            ST_NRD: n_state = ST_NCHK;
            ST_NCHK: begin
                if (nd_rd.key == '0) n_state = ST_ABSENT;
                else if (nd_rd.key == r_key) n_state = ST_FOUND;
                else if (!link_ok(nd_rd.link) || r_steps == LW'(POOL_NODES - 1))
                    n_state = ST_ABSENT;
                else n_state = ST_NRD;
            end
            ST_FOUND: begin
                if (!is_add && !is_rm) n_state = ST_IDLE;
                else if (!r_hit_head) n_state = ST_RMN_PREV;
                else if (link_ok(r_head.link)) n_state = ST_RMH_RD;
                else n_state = is_add ? ST_HRD : ST_IDLE;
            end
            ST_RMH_RD:   n_state = ST_RMH_WR;
            ST_RMH_WR:   n_state = is_add ? ST_HRD : ST_IDLE;
            ST_RMN_PREV: n_state = ST_RMN_REL;
            ST_RMN_REL:  n_state = is_add ? ST_HRD : ST_IDLE;
            ST_ABSENT: begin
                if (is_add && r_head.key != '0 && link_ok(r_free)) n_state = ST_ADD_RD;
                else n_state = ST_IDLE;
            end
            ST_ADD_RD:   n_state = ST_ADD_NODE;
            ST_ADD_NODE: n_state = ST_ADD_LINK;
            ST_ADD_LINK: n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Datapath, RAM control and result
    always_comb begin
        n_op       = r_op;
        n_key      = r_key;
        n_val      = r_val;
        n_nb       = r_nb;
        n_bucket   = r_bucket;
        n_head     = r_head;
        n_nent     = r_nent;
        n_pent     = r_pent;
        n_prev     = r_prev;
        n_cur      = r_cur;
        n_free     = r_free;
        n_new      = r_new;
        n_steps    = r_steps;
        n_hit_head = r_hit_head;
        n_clr      = r_clr;
        n_done     = 1'b0;
        n_res      = r_res;
        h_we       = 1'b0;
        nd_we      = 1'b0;
        h_addr     = r_bucket;
        nd_addr    = idx_of(r_cur);
        h_wdata    = '0;
        nd_wdata   = '0;
        div_start  = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                // empty each bucket and thread each node onto the free list
                h_addr  = r_clr[BW-1:0];
                nd_addr = r_clr[NW-1:0];
                h_we    = (r_clr < CLW'(BUCKETS));
                nd_we   = (r_clr < CLW'(POOL_NODES));
                if (r_clr < CLW'(POOL_NODES - 1))
                    nd_wdata.link = LW'(r_clr + CLW'(2));
                n_clr = r_clr + CLW'(1);
            end
            ST_IDLE: begin
                if (start) begin
                    n_op  = i_item.operation;
                    n_key = i_item.key;
                    n_val = i_item.value;
                    // clamp bucket count to 1..BUCKETS
                    if (r_cfg == '0) n_nb = NBW'(1);
                    else if (32'(r_cfg) > 32'(BUCKETS)) n_nb = NBW'(BUCKETS);
                    else n_nb = NBW'(r_cfg);
                    if (i_item.key == '0) begin
                        n_done = 1'b1;
                        n_res  = '{status: STAT_KEYZERO, found_value: '0};
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) n_bucket = div_rem[BW-1:0];
            end
            ST_HCHK: begin
                n_head     = h_rd;
                n_hit_head = (h_rd.key == r_key);
                n_prev     = '0;
                n_cur      = h_rd.link;
                n_steps    = '0;
            end
            ST_NCHK: begin
                if (nd_rd.key == r_key) begin
                    n_nent     = nd_rd;
                    n_hit_head = 1'b0;
                end else begin
                    // advance; the last node visited is the tail for an add
                    n_pent  = nd_rd;
                    n_prev  = r_cur;
                    n_cur   = nd_rd.link;
                    n_steps = r_steps + LW'(1);
                end
            end
            ST_FOUND: begin
                if (!is_add && !is_rm) begin
                    n_done = 1'b1;
                    n_res  = '{status: STAT_OK,
                              found_value: r_hit_head ? r_head.value : r_nent.value};
                end else if (r_hit_head && !link_ok(r_head.link)) begin
                    h_we    = 1'b1;
                    h_wdata = '0;
                    if (is_rm) begin
                        n_done = 1'b1;
                        n_res  = '{status: STAT_OK, found_value: '0};
                    end
                end
            end
            ST_RMH_RD: begin
                nd_addr = idx_of(r_head.link);
            end
            ST_RMH_WR: begin
                // pull the next node into the head, then free it
                h_we     = 1'b1;
                h_wdata  = nd_rd;
                nd_we    = 1'b1;
                nd_addr  = idx_of(r_head.link);
                nd_wdata = '{key: nd_rd.key, value: nd_rd.value, link: r_free};
                n_free   = r_head.link;
                if (is_rm) begin
                    n_done = 1'b1;
                    n_res  = '{status: STAT_OK, found_value: '0};
                end
            end
            ST_RMN_PREV: begin
                if (r_prev == '0) begin
                    h_we    = 1'b1;
                    h_wdata = '{key: r_head.key, value: r_head.value, link: r_nent.link};
                end else begin
                    nd_we    = 1'b1;
                    nd_addr  = idx_of(r_prev);
                    nd_wdata = '{key: r_pent.key, value: r_pent.value, link: r_nent.link};
                end
            end
            ST_RMN_REL: begin
                nd_we    = 1'b1;
                nd_addr  = idx_of(r_cur);
                nd_wdata = '{key: r_nent.key, value: r_nent.value, link: r_free};
                n_free   = r_cur;
                if (is_rm) begin
                    n_done = 1'b1;
                    n_res  = '{status: STAT_OK, found_value: '0};
                end
            end
            ST_ABSENT: begin
                if (!is_add) begin
                    n_done = 1'b1;
                    n_res  = '{status: STAT_MISS, found_value: '0};
                end else if (r_head.key == '0) begin
                    h_we    = 1'b1;
                    h_wdata = '{key: r_key, value: r_val, link: '0};
                    n_done  = 1'b1;
                    n_res   = '{status: STAT_OK, found_value: '0};
                end else if (!link_ok(r_free)) begin
                    n_done = 1'b1;
                    n_res  = '{status: STAT_FULL, found_value: '0};
                end
            end
            ST_ADD_RD: begin
                nd_addr = idx_of(r_free);
            end
            ST_ADD_NODE: begin
                // take the free head and fill it
                nd_we    = 1'b1;
                nd_addr  = idx_of(r_free);
                nd_wdata = '{key: r_key, value: r_val, link: '0};
                n_new    = r_free;
                n_free   = nd_rd.link;
            end
            ST_ADD_LINK: begin
                if (r_prev == '0) begin
                    h_we    = 1'b1;
                    h_wdata = '{key: r_head.key, value: r_head.value, link: r_new};
                end else begin
                    nd_we    = 1'b1;
                    nd_addr  = idx_of(r_prev);
                    nd_wdata = '{key: r_pent.key, value: r_pent.value, link: r_new};
                end
                n_done = 1'b1;
                n_res  = '{status: STAT_OK, found_value: '0};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cfg   <= CFG_W'(1999);
            r_free  <= LW'(1);
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_cfg <= i_cfg_wdata;
            r_free  <= n_free;
            r_clr   <= n_clr;
            r_done  <= n_done;
        end
        r_op       <= n_op;
        r_key      <= n_key;
        r_val      <= n_val;
        r_nb       <= n_nb;
        r_bucket   <= n_bucket;
        r_head     <= n_head;
        r_nent     <= n_nent;
        r_pent     <= n_pent;
        r_prev     <= n_prev;
        r_cur      <= n_cur;
        r_new      <= n_new;
        r_steps    <= n_steps;
        r_hit_head <= n_hit_head;
        r_res      <= n_res;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_done)
        else $error("result during clearing pass");

    a_free_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_CLEAR) |-> (r_free <= LW'(POOL_NODES)))
        else $error("free list head out of range");

    a_bucket_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HRD) |-> (NBW'(r_bucket) < r_nb))
        else $error("bucket index not below bucket count");
endmodule
`default_nettype wire

[tb/chained_hash_table_engine_core_test.sv]
// Self-checking testbench for chained_hash_table_engine_core: finds, adds and
// removes against an in-bench hash table predictor. Depends on cht_pkg and the RTL.
`timescale 1ns / 100ps
module chained_hash_table_engine_core_test;
    import cht_pkg::*;

    localparam int NBKT     = 2048;
    localparam int NPOOL    = 1024;
    localparam int STALL_MAX = 20000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_item      i_item = '0;
    logic       o_done;
    t_result    o_result;
    logic       i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    chained_hash_table_engine_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the table; links hold 0 for none or n+1 for node n.
    logic [31:0] tbl_head_key  [NBKT];
    logic [31:0] tbl_head_val  [NBKT];
    logic [10:0] tbl_head_link [NBKT];
    logic [31:0] tbl_node_key  [NPOOL];
    logic [31:0] tbl_node_val  [NPOOL];
    logic [10:0] tbl_node_link [NPOOL];
    logic [10:0] tbl_free;
    int unsigned tbl_buckets;

    t_item   pending_items[$];
    t_result expected_results[$];
    logic [31:0] known_keys[$];
    int unsigned sender_idle_pct = 0;
    int unsigned fail_count = 0;
    int unsigned result_count = 0;
    int unsigned full_count = 0;
    int unsigned miss_count = 0;
    int unsigned hit_count = 0;
    int unsigned quiet_cycles = 0;

    function automatic bit link_valid(logic [10:0] l);
        return l >= 1 && l <= NPOOL;
    endfunction

    // Walk the bucket for a key: -1 absent, 0 in head, else its link code.
    function automatic int locate_key(int b, logic [31:0] k, output logic [10:0] prv);
        logic [10:0] p;
        logic [10:0] cur;
        prv = '0;
        p = '0;
        if (tbl_head_key[b] == 0) return -1;
        if (tbl_head_key[b] == k) return 0;
        cur = tbl_head_link[b];
        for (int s = 0; s < NPOOL; s++) begin
            if (!link_valid(cur)) return -1;
            if (tbl_node_key[cur-1] == 0) return -1;
            if (tbl_node_key[cur-1] == k) begin
                prv = p;
                return int'(cur);
            end
            p = cur;
            cur = tbl_node_link[cur-1];
        end
        return -1;
    endfunction

    function automatic void free_node(logic [10:0] l);
        tbl_node_link[l-1] = tbl_free;
        tbl_free = l;
    endfunction

    function automatic bit unlink_key(int b, logic [31:0] k);
        logic [10:0] prv;
        logic [10:0] nx;
        int where;
        where = locate_key(b, k, prv);
        if (where < 0) return 1'b0;
        if (where == 0) begin
            nx = tbl_head_link[b];
            if (link_valid(nx)) begin
                // pull the first chain node up into the head slot
                tbl_head_key[b]  = tbl_node_key[nx-1];
                tbl_head_val[b]  = tbl_node_val[nx-1];
                tbl_head_link[b] = tbl_node_link[nx-1];
                free_node(nx);
            end else begin
                tbl_head_key[b]  = '0;
                tbl_head_val[b]  = '0;
                tbl_head_link[b] = '0;
            end
        end else begin
            if (prv == 0) tbl_head_link[b] = tbl_node_link[where-1];
            else tbl_node_link[prv-1] = tbl_node_link[where-1];
            free_node(11'(where));
        end
        return 1'b1;
    endfunction

    function automatic logic [1:0] insert_key(int b, logic [31:0] k, logic [31:0] v);
        logic [10:0] prv;
        logic [10:0] tail;
        logic [10:0] cur;
        logic [10:0] n;
        bit dummy;
        tail = '0;
        if (locate_key(b, k, prv) >= 0) dummy = unlink_key(b, k);
        if (tbl_head_key[b] == 0) begin
            tbl_head_key[b]  = k;
            tbl_head_val[b]  = v;
            tbl_head_link[b] = '0;
            return STAT_OK;
        end
        if (!link_valid(tbl_free)) return STAT_FULL;
        cur = tbl_head_link[b];
        for (int s = 0; s < NPOOL; s++) begin
            if (!link_valid(cur)) break;
            tail = cur;
            cur = tbl_node_link[cur-1];
        end
        n = tbl_free;
        tbl_free = tbl_node_link[n-1];
        tbl_node_key[n-1]  = k;
        tbl_node_val[n-1]  = v;
        tbl_node_link[n-1] = '0;
        if (tail == 0) tbl_head_link[b] = n;
        else tbl_node_link[tail-1] = n;
        return STAT_OK;
    endfunction

    function automatic t_result predict_result(t_item it);
        t_result r;
        logic [10:0] prv;
        int b;
        int where;
        int unsigned nb;
        r = '0;
        if (it.key == 0) begin
            r.status = STAT_KEYZERO;
            return r;
        end
        nb = (tbl_buckets == 0) ? 1 : (tbl_buckets > NBKT ? NBKT : tbl_buckets);
        b = int'(it.key % nb);
        if (it.operation == OP_ADD) begin
            r.status = insert_key(b, it.key, it.value);
        end else if (it.operation == OP_REMOVE) begin
            r.status = unlink_key(b, it.key) ? STAT_OK : STAT_MISS;
        end else begin
            // unused code 3 behaves as a find
            where = locate_key(b, it.key, prv);
            if (where < 0) begin
                r.status = STAT_MISS;
            end else begin
                r.status = STAT_OK;
                r.found_value = (where == 0) ? tbl_head_val[b] : tbl_node_val[where-1];
            end
        end
        return r;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < NBKT; i++) begin
            tbl_head_key[i] = '0;
            tbl_head_val[i] = '0;
            tbl_head_link[i] = '0;
        end
        for (int i = 0; i < NPOOL; i++) begin
            tbl_node_key[i] = '0;
            tbl_node_val[i] = '0;
            tbl_node_link[i] = (i + 1 < NPOOL) ? 11'(i + 2) : 11'd0;
        end
        tbl_free = 11'd1;
        tbl_buckets = 1999;
    endfunction

    // Driver: predict each item as it is accepted, then present the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) expected_results.push_back(predict_result(i_item));
            if (!start || !busy) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    i_item <= pending_items.pop_front();
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed result must match the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_done || (start && !busy)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_MAX) begin
                $display("%0t: watchdog expired, no progress for %0d cycles", $time, STALL_MAX);
                $display("Some tests failed");
                $finish;
            end
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result status=%0d value=%h", $time,
                             o_result.status, o_result.found_value);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    result_count <= result_count + 1;
                    if (o_result.status != want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, o_result.status);
                        fail_count <= fail_count + 1;
                    end else if (o_result.found_value != want.found_value) begin
                        $display("%0t: found_value expected %h actual %h", $time,
                                 want.found_value, o_result.found_value);
                        fail_count <= fail_count + 1;
                    end
                    case (want.status)
                        STAT_FULL: full_count <= full_count + 1;
                        STAT_MISS: miss_count <= miss_count + 1;
                        STAT_OK:   hit_count <= hit_count + 1;
                        default: ;
                    endcase
                end
            end
        end
    end

    task automatic queue_item(logic [1:0] op, logic [31:0] k, logic [31:0] v);
        t_item it;
        it.operation = op;
        it.key = k;
        it.value = v;
        pending_items.push_back(it);
        if (op == OP_ADD && k != 0) known_keys.push_back(k);
    endtask

    // Hold until everything queued has been answered, then a short margin.
    task automatic wait_drained();
        while (pending_items.size() > 0 || expected_results.size() > 0 || start || busy)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_buckets(int unsigned nb);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= CFG_W'(nb);
        tbl_buckets = nb & 12'hFFF;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        repeat (2) @(posedge i_clk);
    endtask

    // Mixed traffic; recent keys give hits, fresh keys give misses and new entries.
    task automatic queue_random(int count, int recent);
        logic [1:0]  op;
        logic [31:0] k;
        int sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            op = (sel < 45) ? OP_ADD : (sel < 70) ? OP_FIND : (sel < 96) ? OP_REMOVE : 2'd3;
            sel = $urandom_range(99);
            if (sel < 2) k = '0;
            else if (sel < 70 && known_keys.size() > 0)
                k = known_keys[known_keys.size() - 1 -
                               $urandom_range((known_keys.size() < recent ?
                                               known_keys.size() : recent) - 1)];
            else k = $urandom;
            queue_item(op, k, ($urandom_range(9) == 0) ? 32'd0 : $urandom);
        end
    endtask

    localparam logic [31:0] KA = 32'd12345;
    localparam logic [31:0] NB0 = 32'd1999;

    initial begin
        clear_table();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // let the clearing pass finish
        while (busy) @(posedge i_clk);

        // Directed: key zero, replace, stored zero, chain head, middle and tail removal.
        sender_idle_pct = 9;
        queue_item(OP_ADD, 32'd0, 32'hFFFF_FFFF);
        queue_item(OP_FIND, 32'd0, 32'd0);
        queue_item(OP_REMOVE, 32'd0, 32'd0);
        queue_item(2'd3, 32'd0, 32'd0);
        queue_item(OP_ADD, KA, 32'hFFFF_FFFF);
        queue_item(OP_FIND, KA, 32'd0);
        queue_item(2'd3, KA, 32'hFFFF_FFFF);
        queue_item(OP_ADD, KA, 32'd0);
        queue_item(OP_FIND, KA, 32'd0);
        queue_item(OP_ADD, KA + NB0, 32'd1);
        queue_item(OP_ADD, KA + 2 * NB0, 32'd2);
        queue_item(OP_ADD, KA + 3 * NB0, 32'd3);
        queue_item(OP_ADD, KA + NB0, 32'd4);
        queue_item(OP_REMOVE, KA + 2 * NB0, 32'd0);
        queue_item(OP_FIND, KA + 3 * NB0, 32'd0);
        queue_item(OP_REMOVE, KA, 32'd0);
        queue_item(OP_FIND, KA + NB0, 32'd0);
        queue_item(OP_REMOVE, KA + NB0, 32'd0);
        queue_item(OP_REMOVE, KA + NB0, 32'd0);
        queue_item(OP_FIND, 32'hFFFF_FFFF, 32'd0);
        queue_item(OP_ADD, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
        queue_item(OP_FIND, 32'hFFFF_FFFF, 32'd0);
        queue_item(OP_REMOVE, KA + 3 * NB0, 32'd0);
        wait_drained();

        // Largest bucket count, light sender gaps.
        write_buckets(2048);
        queue_random(200, 40);
        wait_drained();

        // Zero reads as one bucket: long chains in a single bucket.
        write_buckets(0);
        queue_random(120, 16);
        wait_drained();

        // Sixteen buckets: drain the node pool with fresh adds, then mix.
        sender_idle_pct = 68;
        write_buckets(16);
        for (int n = 0; n < 1050; n++) queue_item(OP_ADD, $urandom | 32'h1, $urandom);
        queue_random(100, 200);
        wait_drained();

        // Oversized setting saturates; no sender gaps from here on.
        sender_idle_pct = 0;
        write_buckets(4095);
        queue_random(100, 60);
        wait_drained();

        write_buckets(7);
        queue_random(100, 30);
        wait_drained();
        write_buckets(1);
        queue_random(60, 20);
        wait_drained();

        repeat (50) @(posedge i_clk);
        $display("Checked %0d results: %0d ok, %0d not found, %0d pool full,", result_count,
                 hit_count, miss_count, full_count);
        $display("across bucket counts 1999, 2048, 0, 16, 4095, 7 and 1.");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
